// ===== rtl/protobuf_wire_field_scanner_assert.svh =====
// Assertion helpers for the wire scanner. Clocked on clk_i, idle during reset.
`ifndef PROTOBUF_WIRE_FIELD_SCANNER_ASSERT_SVH
`define PROTOBUF_WIRE_FIELD_SCANNER_ASSERT_SVH

`define PBWFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expr must never be true at a clock edge
`define PBWFS_ASSERT_NEVER(lbl, expr, msg) \
  `PBWFS_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/pbwfs_pkg.sv =====
`timescale 1ns / 1ps

package pbwfs_pkg;

  localparam int MaxMessageBytesDef = 65536;
  localparam int MaxVarintBytes     = 10;
  localparam int PosW               = 17;
  localparam int OutDataW           = 136;

  // parser phases
  localparam logic [2:0] PH_KEY   = 3'd0;
  localparam logic [2:0] PH_VALUE = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_FIX32 = 3'd4;

  // record kinds
  localparam logic [1:0] KIND_FIELD = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  // wire types
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_VARINT    = 3'd1;
  localparam logic [2:0] ERR_KEY_BIG   = 3'd2;
  localparam logic [2:0] ERR_FIELD0    = 3'd3;
  localparam logic [2:0] ERR_WIRE      = 3'd4;
  localparam logic [2:0] ERR_LEN_LONG  = 3'd5;
  localparam logic [2:0] ERR_TRUNC     = 3'd6;
  localparam logic [2:0] ERR_MSG_LONG  = 3'd7;

  typedef struct packed {
    logic [2:0]      phase;
    logic [63:0]     acc;
    logic [3:0]      cnt;
    logic [28:0]     field_num;
    logic [2:0]      wire_type;
    logic [PosW-1:0] offset;
    logic [15:0]     left;
    logic [PosW-1:0] pos;
    logic [2:0]      err;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [28:0] field_num;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic [15:0] offset;
    logic [15:0] length;
    logic [2:0]  err;
  } rec_t;

  localparam state_t StateReset = '{
    phase: PH_KEY, acc: 64'd0, cnt: 4'd0, field_num: 29'd0, wire_type: 3'd0,
    offset: '0, left: 16'd0, pos: '0, err: ERR_NONE
  };

endpackage

// ===== rtl/pbwfs_step.sv =====
`timescale 1ns / 1ps

// Next-state and record logic for one item of the scanner.
module pbwfs_step #(
  parameter int MaxMessageBytes = pbwfs_pkg::MaxMessageBytesDef
) (
  input  pbwfs_pkg::state_t st_i,
  input  logic [7:0]        byte_i,
  input  logic              eom_i,
  output pbwfs_pkg::state_t st_o,
  output logic              emit_o,
  output pbwfs_pkg::rec_t   rec_o
);

  localparam logic [pbwfs_pkg::PosW-1:0] MaxPos = pbwfs_pkg::PosW'(MaxMessageBytes);
  localparam logic [3:0] VarLast = 4'(pbwfs_pkg::MaxVarintBytes - 1);
  localparam logic [3:0] VarMax  = 4'(pbwfs_pkg::MaxVarintBytes);

  logic [pbwfs_pkg::PosW-1:0] pos_n;
  logic [pbwfs_pkg::PosW-1:0] remain;
  logic [63:0]                acc_v;
  logic [3:0]                 cnt_n;
  logic                       v_done;
  logic                       v_bad;
  logic [1:0]                 fix_sel;
  logic [63:0]                acc_fix;
  logic [15:0]                left_n;

  always_comb begin
    pos_n   = st_i.pos + 1'b1;
    remain  = MaxPos - pos_n;
    acc_v   = st_i.acc | (64'(byte_i[6:0]) << (7 * 32'(st_i.cnt)));
    cnt_n   = st_i.cnt + 4'd1;
    v_done  = !byte_i[7];
    // tenth byte may only carry bit 0; an eleventh byte never completes
    v_bad   = (st_i.cnt >= VarMax) ||
              ((st_i.cnt == VarLast) && (byte_i[7:1] != 7'd0)) ||
              (!v_done && (cnt_n >= VarMax));
    fix_sel = 2'd0 - st_i.left[1:0];
    acc_fix = st_i.acc | (64'(byte_i) << {fix_sel, 3'b000});
    left_n  = st_i.left - 16'd1;
  end

  always_comb begin
    st_o   = st_i;
    emit_o = 1'b0;
    rec_o  = '0;

    if (eom_i) begin
      emit_o = 1'b1;
      st_o   = pbwfs_pkg::StateReset;
      if (st_i.err != pbwfs_pkg::ERR_NONE) begin
        rec_o.kind = pbwfs_pkg::KIND_BAD;
        rec_o.err  = st_i.err;
      end else if (st_i.phase != pbwfs_pkg::PH_KEY) begin
        rec_o.kind = pbwfs_pkg::KIND_BAD;
        rec_o.err  = pbwfs_pkg::ERR_TRUNC;
      end else begin
        rec_o.kind = pbwfs_pkg::KIND_OK;
      end
    end else if (st_i.err != pbwfs_pkg::ERR_NONE) begin
      // drop bytes until the end item
    end else if (st_i.pos >= MaxPos) begin
      st_o.err = pbwfs_pkg::ERR_MSG_LONG;
    end else begin
      st_o.pos = pos_n;
      case (st_i.phase)
        pbwfs_pkg::PH_KEY: begin
          if (v_bad) begin
            st_o.err = pbwfs_pkg::ERR_VARINT;
          end else if (!v_done) begin
            st_o.acc = acc_v;
            st_o.cnt = cnt_n;
          end else if (acc_v[63:32] != 32'd0) begin
            st_o.err = pbwfs_pkg::ERR_KEY_BIG;
          end else if (acc_v[31:3] == 29'd0) begin
            st_o.err = pbwfs_pkg::ERR_FIELD0;
          end else begin
            st_o.field_num = acc_v[31:3];
            st_o.wire_type = acc_v[2:0];
            st_o.offset    = pos_n;
            st_o.acc       = 64'd0;
            st_o.cnt       = 4'd0;
            case (acc_v[2:0])
              pbwfs_pkg::WT_VARINT: st_o.phase = pbwfs_pkg::PH_VALUE;
              pbwfs_pkg::WT_FIX64: begin
                st_o.phase = pbwfs_pkg::PH_SKIP;
                st_o.left  = 16'd8;
              end
              pbwfs_pkg::WT_LEN: st_o.phase = pbwfs_pkg::PH_LEN;
              pbwfs_pkg::WT_FIX32: begin
                st_o.phase = pbwfs_pkg::PH_FIX32;
                st_o.left  = 16'd4;
              end
              default: st_o.err = pbwfs_pkg::ERR_WIRE;
            endcase
          end
        end
        pbwfs_pkg::PH_VALUE: begin
          if (v_bad) begin
            st_o.err = pbwfs_pkg::ERR_VARINT;
          end else if (!v_done) begin
            st_o.acc = acc_v;
            st_o.cnt = cnt_n;
          end else begin
            emit_o      = 1'b1;
            rec_o.value = acc_v;
          end
        end
        pbwfs_pkg::PH_LEN: begin
          if (v_bad) begin
            st_o.err = pbwfs_pkg::ERR_VARINT;
          end else if (!v_done) begin
            st_o.acc = acc_v;
            st_o.cnt = cnt_n;
          end else if (acc_v > 64'(remain)) begin
            st_o.err = pbwfs_pkg::ERR_LEN_LONG;
          end else begin
            st_o.offset = pos_n;
            if (acc_v == 64'd0) begin
              emit_o      = 1'b1;
              rec_o.value = 64'd0;
            end else begin
              st_o.acc   = acc_v;
              st_o.left  = acc_v[15:0];
              st_o.phase = pbwfs_pkg::PH_SKIP;
            end
          end
        end
        pbwfs_pkg::PH_SKIP: begin
          st_o.left = left_n;
          if (left_n == 16'd0) begin
            emit_o      = 1'b1;
            rec_o.value = (st_i.wire_type == pbwfs_pkg::WT_LEN) ? st_i.acc : 64'd0;
          end
        end
        pbwfs_pkg::PH_FIX32: begin
          st_o.acc  = acc_fix;
          st_o.left = left_n;
          if (left_n == 16'd0) begin
            emit_o      = 1'b1;
            rec_o.value = acc_fix;
          end
        end
        default: begin
          st_o.phase = pbwfs_pkg::PH_KEY;
          st_o.acc   = 64'd0;
          st_o.cnt   = 4'd0;
        end
      endcase

      if (emit_o) begin
        rec_o.kind      = pbwfs_pkg::KIND_FIELD;
        rec_o.field_num = st_i.field_num;
        rec_o.wire_type = st_i.wire_type;
        rec_o.offset    = st_o.offset[15:0];
        rec_o.length    = 16'(pos_n - st_o.offset);
        rec_o.err       = pbwfs_pkg::ERR_NONE;
        st_o.phase      = pbwfs_pkg::PH_KEY;
        st_o.acc        = 64'd0;
        st_o.cnt        = 4'd0;
      end
    end
  end

endmodule

// ===== rtl/protobuf_wire_field_scanner.sv =====
`timescale 1ns / 1ps
// A field record or verdict leaves after its closing item is accepted, passing through the
// input register, then the result register.
// Throughput: one item per cycle; the input side stalls only while the result register is full
// and not taken.
// Reset (rst_ni low, async): queues empty, parser back to the key state, no error pending.

module protobuf_wire_field_scanner #(
  parameter int MaxMessageBytes = pbwfs_pkg::MaxMessageBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] data_byte
  input  logic                          s_axis_tlast_i,  // end_of_message
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [28:0] field_number, [31:29] wire_type, [95:32] field_value,
  // [111:96] payload_offset, [127:112] payload_length, [130:128] error_code, rest 0
  output logic [pbwfs_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [1:0]                    m_axis_tuser_o   // record_kind
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              in_eom_q;
  logic              s_accept;
  logic              fire;
  pbwfs_pkg::state_t st_q, st_d;
  logic              emit;
  pbwfs_pkg::rec_t   rec_d, rec_q;
  logic              out_valid_q, out_valid_d;

  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  pbwfs_step #(
    .MaxMessageBytes(MaxMessageBytes)
  ) u_step (
    .st_i  (st_q),
    .byte_i(in_byte_q),
    .eom_i (in_eom_q),
    .st_o  (st_d),
    .emit_o(emit),
    .rec_o (rec_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= pbwfs_pkg::StateReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_eom_q  <= s_axis_tlast_i;
    end
    if (fire && emit) begin
      rec_q <= rec_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = rec_q.kind;
  assign m_axis_tdata_o  = {5'd0, rec_q.err, rec_q.length, rec_q.offset, rec_q.value,
                            rec_q.wire_type, rec_q.field_num};

`include "protobuf_wire_field_scanner_assert.svh"

  `PBWFS_ASSERT(a_eom_gives_verdict, (fire && in_eom_q) |=> (m_axis_tvalid_o && (m_axis_tuser_o == pbwfs_pkg::KIND_OK || m_axis_tuser_o == pbwfs_pkg::KIND_BAD)), "end item produced no verdict")
  `PBWFS_ASSERT(a_eom_clears_state, (fire && in_eom_q) |=> (st_q.phase == pbwfs_pkg::PH_KEY && st_q.err == pbwfs_pkg::ERR_NONE && st_q.pos == '0), "parser not reset after end item")
  `PBWFS_ASSERT(a_held_item_kept, (in_valid_q && !fire) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_eom_q)), "held item lost")
  `PBWFS_ASSERT_NEVER(a_err_only_bad, m_axis_tvalid_o && m_axis_tuser_o != pbwfs_pkg::KIND_BAD && rec_q.err != pbwfs_pkg::ERR_NONE, "error code on non-failing record")

endmodule
